// ===== design/cone_centerline_densifier_unit_assert.svh =====
// Assertion macros for the densifier block
`ifndef CONE_CENTERLINE_DENSIFIER_UNIT_ASSERT_SVH
`define CONE_CENTERLINE_DENSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define CCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("densifier assertion failed");

// next-cycle implication
`define CCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("densifier assertion failed");

`endif

// ===== design/ccd_pkg.sv =====
package ccd_pkg;

   localparam int MAX_LEFT_CONES     = 64;
   localparam int MAX_SEGMENT_POINTS = 64;
   localparam int COORD_FRAC_BITS    = 8;

   localparam int COORD_W    = 24;
   localparam int STEP_W     = 16;
   localparam int IDX_W      = $clog2(MAX_LEFT_CONES);
   localparam int CNT_W      = $clog2(MAX_LEFT_CONES + 1);
   localparam int NPT_W      = $clog2(MAX_SEGMENT_POINTS + 1);
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int ROOT_W     = DIFF_W;
   localparam int SREM_W     = ROOT_W + 3;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIVD_W     = STEP_W + DIFF_W;
   localparam int DIV_STEPS  = DIVD_W;
   localparam int ITER_W     = $clog2(DIV_STEPS + 1);
   localparam int ACC_W      = STEP_W + NPT_W;

   localparam logic [STEP_W-1:0] STEP_RESET =
      STEP_W'((((2 ** COORD_FRAC_BITS) * 2) + 5) / 10);

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_RIGHT = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] STAT_NORMAL = 2'd0;
   localparam logic [1:0] STAT_CAPPED = 2'd1;
   localparam logic [1:0] STAT_NOLEFT = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_SQUARE, S_COMPARE, S_MIDPOINT, S_DELTA, S_SQRT_LOAD,
      S_SQRT, S_NDIV_LOAD, S_NDIV, S_NCHECK, S_MUL, S_XDIV_LOAD, S_XDIV,
      S_XSAVE, S_YDIV, S_YSAVE, S_EMIT, S_ERROR
   } ccd_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_START, OP_SQUARE, OP_COMPARE, OP_MIDPOINT,
      OP_DELTA, OP_SQRT_LOAD, OP_SQRT_STEP, OP_NDIV_LOAD, OP_DIV_STEP,
      OP_NCHECK, OP_MUL, OP_XDIV_LOAD, OP_XSAVE, OP_YSAVE, OP_EMIT, OP_ERROR
   } ccd_op_type;

   typedef struct packed {
      ccd_op_type op;
   } ccd_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic idx_last;
      logic prev_valid;
      logic it_last;
      logic q_zero;
      logic pt_last;
      logic out_free;
   } ccd_status_type;

endpackage

// ===== design/ccd_ram.sv =====
module ccd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ccd_ctrl.sv =====
module ccd_ctrl import ccd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_type,
   output logic           req_stall,
   input  ccd_status_type status,
   output ccd_cmd_type    cmd
);

   ccd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_type == REQ_RIGHT) begin
               state_in = status.cnt_zero ? S_ERROR : S_READ;
            end
         end
         S_READ:      state_in = S_SQUARE;
         S_SQUARE:    state_in = S_COMPARE;
         S_COMPARE:   state_in = status.idx_last ? S_MIDPOINT : S_READ;
         S_MIDPOINT:  state_in = status.prev_valid ? S_DELTA : S_IDLE;
         S_DELTA:     state_in = S_SQRT_LOAD;
         S_SQRT_LOAD: state_in = S_SQRT;
         S_SQRT:      if (status.it_last) state_in = S_NDIV_LOAD;
         S_NDIV_LOAD: state_in = S_NDIV;
         S_NDIV:      if (status.it_last) state_in = S_NCHECK;
         S_NCHECK:    state_in = status.q_zero ? S_IDLE : S_MUL;
         S_MUL:       state_in = S_XDIV_LOAD;
         S_XDIV_LOAD: state_in = S_XDIV;
         S_XDIV:      if (status.it_last) state_in = S_XSAVE;
         S_XSAVE:     state_in = S_YDIV;
         S_YDIV:      if (status.it_last) state_in = S_YSAVE;
         S_YSAVE:     state_in = S_EMIT;
         S_EMIT:      if (status.out_free && status.pt_last) state_in = S_IDLE;
         S_ERROR:     if (status.out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_LOAD:  cmd.op = OP_LOAD;
                  REQ_RIGHT: cmd.op = OP_START;
                  REQ_CLEAR: cmd.op = OP_CLEAR;
                  default:   cmd.op = OP_NONE;
               endcase
            end
         end
         S_SQUARE:    cmd.op = OP_SQUARE;
         S_COMPARE:   cmd.op = OP_COMPARE;
         S_MIDPOINT:  cmd.op = OP_MIDPOINT;
         S_DELTA:     cmd.op = OP_DELTA;
         S_SQRT_LOAD: cmd.op = OP_SQRT_LOAD;
         S_SQRT:      cmd.op = OP_SQRT_STEP;
         S_NDIV_LOAD: cmd.op = OP_NDIV_LOAD;
         S_NDIV:      cmd.op = OP_DIV_STEP;
         S_NCHECK:    cmd.op = OP_NCHECK;
         S_MUL:       cmd.op = OP_MUL;
         S_XDIV_LOAD: cmd.op = OP_XDIV_LOAD;
         S_XDIV:      cmd.op = OP_DIV_STEP;
         S_XSAVE:     cmd.op = OP_XSAVE;
         S_YDIV:      cmd.op = OP_DIV_STEP;
         S_YSAVE:     cmd.op = OP_YSAVE;
         S_EMIT:      if (status.out_free) cmd.op = OP_EMIT;
         S_ERROR:     if (status.out_free) cmd.op = OP_ERROR;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== design/ccd_dp.sv =====
module ccd_dp import ccd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ccd_cmd_type               cmd,
   output ccd_status_type            status,
   input  logic signed [COORD_W-1:0] req_cone_x,
   input  logic signed [COORD_W-1:0] req_cone_y,
   input  logic                      csr_we,
   input  logic [STEP_W-1:0]         csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last
);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [COORD_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [COORD_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic               pvalid_ff, pvalid_in;
   logic [SQ_W-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [DIST_W-1:0]  bestd_ff, bestd_in;
   logic [DIFF_W-1:0]  adx_ff, adx_in, ady_ff, ady_in;
   logic               dxneg_ff, dxneg_in, dyneg_ff, dyneg_in;
   logic [SQ_W-1:0]    rad_ff, rad_in;
   logic [SREM_W-1:0]  srem_ff, srem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [ITER_W-1:0]  it_ff, it_in;
   logic [DIVD_W-1:0]  dq_ff, dq_in;
   logic [ROOT_W-1:0]  drem_ff, drem_in, dsor_ff, dsor_in;
   logic [DIVD_W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic [NPT_W-1:0]   n_ff, n_in, k_ff, k_in;
   logic               capped_ff, capped_in;
   logic [STEP_W-1:0]  qsx_ff, qsx_in, qsy_ff, qsy_in;
   logic [ROOT_W-1:0]  rsx_ff, rsx_in, rsy_ff, rsy_in;
   logic [ACC_W-1:0]   accx_ff, accx_in, accy_ff, accy_in;
   logic [ROOT_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic               ov_ff, ov_in;
   logic [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [1:0]         ost_ff, ost_in;
   logic               olast_ff, olast_in;

   logic [2*COORD_W-1:0]     rd_data;
   logic                     ram_we;
   logic signed [DIFF_W-1:0] ex, ey, dx, dy;
   logic signed [SQ_W-1:0]   ex_sq, ey_sq, dx_sq, dy_sq;
   logic [DIST_W-1:0]        sq_dist;
   logic [DIFF_W-1:0]        msum_x, msum_y;
   logic [SREM_W-1:0]        s_shift, s_trial;
   logic [ROOT_W:0]          d_shift;
   logic [STEP_W-1:0]        step_eff;
   logic [COORD_W-1:0]       offx, offy;
   logic [ROOT_W:0]          rxs, rys;
   logic                     out_free, pt_last;

   ccd_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_LEFT_CONES)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data({req_cone_x, req_cone_y}),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign ram_we   = (cmd.op == OP_LOAD) && (count_ff < CNT_W'(MAX_LEFT_CONES));
   assign step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign out_free = !ov_ff || !rsp_stall;
   assign pt_last  = ((k_ff + 1'b1) == n_ff);

   assign ex    = $signed({cx_ff[COORD_W-1], cx_ff}) -
                  $signed({rd_data[2*COORD_W-1], rd_data[2*COORD_W-1:COORD_W]});
   assign ey    = $signed({cy_ff[COORD_W-1], cy_ff}) -
                  $signed({rd_data[COORD_W-1], rd_data[COORD_W-1:0]});
   assign ex_sq = ex * ex;
   assign ey_sq = ey * ey;
   assign sq_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   assign msum_x = {cx_ff[COORD_W-1], cx_ff} + {bx_ff[COORD_W-1], bx_ff};
   assign msum_y = {cy_ff[COORD_W-1], cy_ff} + {by_ff[COORD_W-1], by_ff};

   assign dx    = $signed({mx_ff[COORD_W-1], mx_ff}) - $signed({px_ff[COORD_W-1], px_ff});
   assign dy    = $signed({my_ff[COORD_W-1], my_ff}) - $signed({py_ff[COORD_W-1], py_ff});
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   assign s_shift = {srem_ff[SREM_W-3:0], rad_ff[SQ_W-1:SQ_W-2]};
   assign s_trial = {1'b0, root_ff, 2'b01};
   assign d_shift = {drem_ff, dq_ff[DIVD_W-1]};

   assign offx = COORD_W'(accx_ff);
   assign offy = COORD_W'(accy_ff);
   assign rxs  = {1'b0, rx_ff} + {1'b0, rsx_ff};
   assign rys  = {1'b0, ry_ff} + {1'b0, rsy_ff};

   always_comb begin
      step_in = step_ff;   count_in = count_ff;  idx_in = idx_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  bx_in = bx_ff;  by_in = by_ff;
      tx_in = tx_ff;  ty_in = ty_ff;  mx_in = mx_ff;  my_in = my_ff;
      px_in = px_ff;  py_in = py_ff;  pvalid_in = pvalid_ff;
      sqx_in = sqx_ff;  sqy_in = sqy_ff;  bestd_in = bestd_ff;
      adx_in = adx_ff;  ady_in = ady_ff;  dxneg_in = dxneg_ff;  dyneg_in = dyneg_ff;
      rad_in = rad_ff;  srem_in = srem_ff;  root_in = root_ff;  it_in = it_ff;
      dq_in = dq_ff;  drem_in = drem_ff;  dsor_in = dsor_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  n_in = n_ff;  k_in = k_ff;  capped_in = capped_ff;
      qsx_in = qsx_ff;  qsy_in = qsy_ff;  rsx_in = rsx_ff;  rsy_in = rsy_ff;
      accx_in = accx_ff;  accy_in = accy_ff;  rx_in = rx_ff;  ry_in = ry_ff;
      ox_in = ox_ff;  oy_in = oy_ff;  ost_in = ost_ff;  olast_in = olast_ff;
      ov_in = ov_ff && rsp_stall;

      if (csr_we) begin
         step_in = csr_wdata;
      end

      case (cmd.op)
         OP_LOAD: begin
            if (ram_we) count_in = count_ff + 1'b1;
         end
         OP_CLEAR: begin
            count_in  = '0;
            px_in     = '0;
            py_in     = '0;
            pvalid_in = 1'b0;
         end
         OP_START: begin
            cx_in  = req_cone_x;
            cy_in  = req_cone_y;
            idx_in = '0;
         end
         OP_SQUARE: begin
            sqx_in = ex_sq;
            sqy_in = ey_sq;
            tx_in  = rd_data[2*COORD_W-1:COORD_W];
            ty_in  = rd_data[COORD_W-1:0];
         end
         OP_COMPARE: begin
            if (idx_ff == '0 || sq_dist < bestd_ff) begin
               bestd_in = sq_dist;
               bx_in    = tx_ff;
               by_in    = ty_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_MIDPOINT: begin
            mx_in = msum_x[DIFF_W-1:1];
            my_in = msum_y[DIFF_W-1:1];
            if (!pvalid_ff) begin
               px_in     = msum_x[DIFF_W-1:1];
               py_in     = msum_y[DIFF_W-1:1];
               pvalid_in = 1'b1;
            end
         end
         OP_DELTA: begin
            sqx_in   = dx_sq;
            sqy_in   = dy_sq;
            dxneg_in = dx[DIFF_W-1];
            dyneg_in = dy[DIFF_W-1];
            adx_in   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            ady_in   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
         end
         OP_SQRT_LOAD: begin
            rad_in  = sqx_ff + sqy_ff;
            srem_in = '0;
            root_in = '0;
            it_in   = ITER_W'(SQRT_STEPS);
         end
         OP_SQRT_STEP: begin
            if (s_shift >= s_trial) begin
               srem_in = s_shift - s_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = s_shift;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in = {rad_ff[SQ_W-3:0], 2'b00};
            it_in  = it_ff - 1'b1;
         end
         OP_NDIV_LOAD: begin
            dq_in   = DIVD_W'(root_ff);
            dsor_in = ROOT_W'(step_eff);
            drem_in = '0;
            it_in   = ITER_W'(DIV_STEPS);
         end
         OP_DIV_STEP: begin
            if (d_shift >= {1'b0, dsor_ff}) begin
               drem_in = ROOT_W'(d_shift - {1'b0, dsor_ff});
               dq_in   = {dq_ff[DIVD_W-2:0], 1'b1};
            end else begin
               drem_in = d_shift[ROOT_W-1:0];
               dq_in   = {dq_ff[DIVD_W-2:0], 1'b0};
            end
            it_in = it_ff - 1'b1;
         end
         OP_NCHECK: begin
            if (dq_ff > DIVD_W'(MAX_SEGMENT_POINTS)) begin
               n_in      = NPT_W'(MAX_SEGMENT_POINTS);
               capped_in = 1'b1;
            end else begin
               n_in      = dq_ff[NPT_W-1:0];
               capped_in = 1'b0;
            end
            if (dq_ff == '0) begin
               px_in = mx_ff;
               py_in = my_ff;
            end
         end
         OP_MUL: begin
            ax_in = step_eff * adx_ff;
            ay_in = step_eff * ady_ff;
         end
         OP_XDIV_LOAD: begin
            dq_in   = ax_ff;
            dsor_in = root_ff;
            drem_in = '0;
            it_in   = ITER_W'(DIV_STEPS);
         end
         OP_XSAVE: begin
            qsx_in  = dq_ff[STEP_W-1:0];
            rsx_in  = drem_ff;
            dq_in   = ay_ff;
            drem_in = '0;
            it_in   = ITER_W'(DIV_STEPS);
         end
         OP_YSAVE: begin
            qsy_in  = dq_ff[STEP_W-1:0];
            rsy_in  = drem_ff;
            accx_in = '0;
            accy_in = '0;
            rx_in   = '0;
            ry_in   = '0;
            k_in    = '0;
         end
         OP_EMIT: begin
            ov_in    = 1'b1;
            ox_in    = px_ff + (dxneg_ff ? (~offx + 1'b1) : offx);
            oy_in    = py_ff + (dyneg_ff ? (~offy + 1'b1) : offy);
            ost_in   = capped_ff ? STAT_CAPPED : STAT_NORMAL;
            olast_in = pt_last;
            if (rxs >= {1'b0, root_ff}) begin
               rx_in   = ROOT_W'(rxs - {1'b0, root_ff});
               accx_in = accx_ff + ACC_W'(qsx_ff) + 1'b1;
            end else begin
               rx_in   = rxs[ROOT_W-1:0];
               accx_in = accx_ff + ACC_W'(qsx_ff);
            end
            if (rys >= {1'b0, root_ff}) begin
               ry_in   = ROOT_W'(rys - {1'b0, root_ff});
               accy_in = accy_ff + ACC_W'(qsy_ff) + 1'b1;
            end else begin
               ry_in   = rys[ROOT_W-1:0];
               accy_in = accy_ff + ACC_W'(qsy_ff);
            end
            k_in = k_ff + 1'b1;
            if (pt_last) begin
               px_in = mx_ff;
               py_in = my_ff;
            end
         end
         OP_ERROR: begin
            ov_in    = 1'b1;
            ox_in    = '0;
            oy_in    = '0;
            ost_in   = STAT_NOLEFT;
            olast_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         count_ff  <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         pvalid_ff <= 1'b0;
         ov_ff     <= 1'b0;
         it_ff     <= '0;
      end else begin
         step_ff   <= step_in;
         count_ff  <= count_in;
         px_ff     <= px_in;
         py_ff     <= py_in;
         pvalid_ff <= pvalid_in;
         ov_ff     <= ov_in;
         it_ff     <= it_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;    cx_ff <= cx_in;      cy_ff <= cy_in;
      bx_ff <= bx_in;      by_ff <= by_in;      tx_ff <= tx_in;    ty_ff <= ty_in;
      mx_ff <= mx_in;      my_ff <= my_in;
      sqx_ff <= sqx_in;    sqy_ff <= sqy_in;    bestd_ff <= bestd_in;
      adx_ff <= adx_in;    ady_ff <= ady_in;
      dxneg_ff <= dxneg_in;  dyneg_ff <= dyneg_in;
      rad_ff <= rad_in;    srem_ff <= srem_in;  root_ff <= root_in;
      dq_ff <= dq_in;      drem_ff <= drem_in;  dsor_ff <= dsor_in;
      ax_ff <= ax_in;      ay_ff <= ay_in;
      n_ff <= n_in;        k_ff <= k_in;        capped_ff <= capped_in;
      qsx_ff <= qsx_in;    qsy_ff <= qsy_in;    rsx_ff <= rsx_in;  rsy_ff <= rsy_in;
      accx_ff <= accx_in;  accy_ff <= accy_in;  rx_ff <= rx_in;    ry_ff <= ry_in;
      ox_ff <= ox_in;      oy_ff <= oy_in;      ost_ff <= ost_in;  olast_ff <= olast_in;
   end

   assign status.cnt_zero   = (count_ff == '0);
   assign status.idx_last   = ((CNT_W'(idx_ff) + 1'b1) == count_ff);
   assign status.prev_valid = pvalid_ff;
   assign status.it_last    = (it_ff == ITER_W'(1));
   assign status.q_zero     = (dq_ff == '0);
   assign status.pt_last    = pt_last;
   assign status.out_free   = out_free;

   assign rsp_valid   = ov_ff;
   assign rsp_point_x = ox_ff;
   assign rsp_point_y = oy_ff;
   assign rsp_status  = ost_ff;
   assign rsp_last    = olast_ff;

endmodule

// ===== design/cone_centerline_densifier_unit.sv =====
// Cone centre-line densifier.
// Input channel req_*: valid/stall; req_type selects load left cone, right cone
// or clear. Load, clear and unused codes give no result.
// A right cone is matched against the N stored left cones (one table read each),
// then an integer square root and three restoring divisions run on the shared
// divider; the points then leave one per cycle while rsp_stall allows. With no
// previous point, or a zero point count, no result is given.
// A right cone with an empty table gives one error result.
// One item is worked on at a time; req_stall is high while busy. Results
// sit in an output register, so the next item is taken while the last
// result still waits. rsp_stall holds the result and pauses point emission.
// csr_we/csr_wdata write the step length; write only while idle.
// Reset (synchronous, active high) empties the table, clears the previous
// point and restores the default step length.
`include "cone_centerline_densifier_unit_assert.svh"
module cone_centerline_densifier_unit import ccd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic signed [COORD_W-1:0] req_cone_x,
   input  logic signed [COORD_W-1:0] req_cone_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last,
   input  logic                      csr_we,
   input  logic [STEP_W-1:0]         csr_wdata
);

   ccd_cmd_type    cmd;
   ccd_status_type status;

   ccd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_type (req_type),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   ccd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_cone_x (req_cone_x),
      .req_cone_y (req_cone_y),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   `CCD_ASSERT_IMPLY(a_noleft_last, clock, reset, rsp_valid && rsp_status == STAT_NOLEFT, rsp_last)
   `CCD_ASSERT_NEXT(a_right_busy, clock, reset, req_valid && !req_stall && req_type == REQ_RIGHT, req_stall)
   `CCD_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status <= STAT_NOLEFT)

endmodule
